@@ design/sedge_pkg.sv @@
// ----------------------------------------------------------------------------
// sedge_pkg: shared types and constants for the Sobel edge threshold block
// Field widths, configuration register indexes, request codes and the
// per-request position flags handed from the position tracker to the datapath.
// ----------------------------------------------------------------------------
package sedge_pkg;

  localparam int DEPTH_W    = 16;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 16;
  localparam int EDGE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = DEPTH_W + 2;
  localparam int SQ_W       = 2 * DEPTH_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // Configuration reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd1000;
  localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd480;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Edge map values
  localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

  // What the position tracker decides for one request
  typedef struct packed {
    logic pix;     // depth pixel: updates line store and window
    logic emit;    // request produces a result
    logic border;  // result is a border pixel (zero gradient)
    logic last;    // result closes the frame
  } pos_info_t;

endpackage

@@ design/sedge_in_if.sv @@
// ----------------------------------------------------------------------------
// sedge_in_if: depth pixel request channel
// Valid/ready channel carrying the request type and the depth sample.
// ----------------------------------------------------------------------------
interface sedge_in_if import sedge_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, output req_type, output depth, input ready);
  modport sink   (input valid, input req_type, input depth, output ready);

endinterface

@@ design/sedge_out_if.sv @@
// ----------------------------------------------------------------------------
// sedge_out_if: edge map result channel
// Valid/ready channel carrying the edge pixel and the end-of-frame mark.
// ----------------------------------------------------------------------------
interface sedge_out_if import sedge_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_res;
  logic              last_of_frame;

  modport source (output valid, output edge_res, output last_of_frame, input ready);
  modport sink   (input valid, input edge_res, input last_of_frame, output ready);

endinterface

@@ design/sedge_ctrl.sv @@
// ----------------------------------------------------------------------------
// sedge_ctrl: raster position tracker
// Tracks input and output positions, decides per request whether a result
// is due, whether it is a border pixel and whether it ends the frame.
// ----------------------------------------------------------------------------
module sedge_ctrl import sedge_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             req_type,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output logic [COL_W-1:0] col,
  output pos_info_t        info
);

  localparam int WCW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

  logic [COL_W-1:0] in_col, in_col_next, out_col, out_col_next, ocol;
  logic [ROW_W-1:0] in_row, in_row_next, out_row, out_row_next, orow;
  logic [WCW-1:0]   fw, weff;
  logic [HCW-1:0]   fh, heff;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  // Clamp the frame size to the supported range
  always_comb begin
    fw = WCW'(frame_width);
    fh = HCW'(frame_height);
    if (fw < WCW'(3)) begin
      weff = WCW'(3);
    end else if (fw > WCW'(MAX_WIDTH)) begin
      weff = WCW'(MAX_WIDTH);
    end else begin
      weff = fw;
    end
    if (fh < HCW'(3)) begin
      heff = HCW'(3);
    end else if (fh > HCW'(MAX_HEIGHT)) begin
      heff = HCW'(MAX_HEIGHT);
    end else begin
      heff = fh;
    end
    wm1 = COL_W'(weff - WCW'(1));
    hm1 = ROW_W'(heff - HCW'(1));
  end

  // Decide the request and the next positions
  always_comb begin
    info         = '0;
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    orow         = '0;
    ocol         = '0;
    if (req_type == REQ_FLUSH) begin
      // drain the frame tail only between frames and only when something is pending
      if (in_row == '0 && in_col == '0 && (out_row != '0 || out_col != '0)) begin
        info.emit   = 1'b1;
        info.border = 1'b1;
        if (out_row >= hm1 && out_col >= wm1) begin
          info.last    = 1'b1;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col >= wm1) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + COL_W'(1);
        end
      end
    end else begin
      info.pix = 1'b1;
      // a new frame drops any undrained tail
      if (in_row == '0 && in_col == '0) begin
        out_row_next = '0;
        out_col_next = '0;
      end
      if (in_row >= ROW_W'(2) || (in_row == ROW_W'(1) && in_col != '0)) begin
        info.emit = 1'b1;
        if (in_col != '0) begin
          orow = in_row - ROW_W'(1);
          ocol = in_col - COL_W'(1);
        end else begin
          orow = in_row - ROW_W'(2);
          ocol = wm1;
        end
        info.border = (orow == '0) || (orow >= hm1) || (ocol == '0) || (ocol >= wm1);
        if (ocol >= wm1) begin
          out_row_next = orow + ROW_W'(1);
          out_col_next = '0;
        end else begin
          out_row_next = orow;
          out_col_next = ocol + COL_W'(1);
        end
      end
      if (in_col >= wm1) begin
        in_col_next = '0;
        in_row_next = (in_row >= hm1) ? '0 : in_row + ROW_W'(1);
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
    end
  end

  assign col = in_col;

  // Advance positions on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // A frame's first pixel restarts the drain position
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_PIXEL && in_row == '0 && in_col == '0)
      |=> (out_row == '0 && out_col == '0))
    else $error("drain position not cleared at frame start");

endmodule

@@ design/sobel_edge_threshold_top.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_threshold_top: streaming 3x3 Sobel edge detector with threshold
// Takes 16-bit depth pixels in raster order and returns a binary edge map
// one row and one column behind; flush requests drain the frame tail.
// ----------------------------------------------------------------------------
// The block takes one request (pixel or flush) every clock cycle as long as
// the result side keeps taking results; a finished result held on the output
// stalls the whole pipeline, the input included. A request passes
// through four registers: line store read and position decode, gradient sums
// with clamping, squaring, and the threshold compare into the result
// register. The two previous rows live in two MAX_WIDTH x 16 line memories,
// each read once per cycle at the current column and written once per cycle
// at the previous pixel's column, both only while the pipeline advances;
// their contents are undefined after reset and need no clearing pass, since
// the first two rows of every frame fill them before any interior pixel
// reads them. The user must write the configuration registers only while no
// request is in flight; the block itself does not enforce this.
module sobel_edge_threshold_top import sedge_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  sedge_in_if.sink              pix_in,
  sedge_out_if.source           edge_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [THR_W-1:0] edge_threshold;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [SQ_W-1:0]  thr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RST;
      frame_width    <= WIDTH_RST;
      frame_height   <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
        CFG_WIDTH:     frame_width    <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:    frame_height   <= cfg_data[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // Keep the squared threshold ready for the compare
  always_ff @(posedge clk) begin
    thr_sq <= edge_threshold * edge_threshold;
  end

  // Pipeline advances unless the result register is held
  logic adv, acc;
  logic o_valid;

  assign adv          = !o_valid || edge_out.ready;
  assign pix_in.ready = adv;
  assign acc          = pix_in.valid && adv;

  // Position tracking
  logic [COL_W-1:0] col;
  pos_info_t        info;

  sedge_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (acc),
    .req_type     (pix_in.req_type),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (col),
    .info         (info)
  );

  // Stage 1: line store read and request capture
  logic [DEPTH_W-1:0] mem_top [MAX_WIDTH];
  logic [DEPTH_W-1:0] mem_mid [MAX_WIDTH];
  logic               s1_valid;
  pos_info_t          s1_info;
  logic [COL_W-1:0]   s1_addr;
  logic [DEPTH_W-1:0] s1_x, s1_t, s1_m;
  logic               s1_wr;

  assign s1_wr = s1_valid && s1_info.pix && adv;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_t <= mem_top[col];
      s1_m <= mem_mid[col];
    end
    if (s1_wr) begin
      mem_top[s1_addr] <= s1_m;
      mem_mid[s1_addr] <= s1_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_info <= info;
      s1_addr <= col;
      s1_x    <= pix_in.depth;
    end
  end

  // Window columns: left column a*, middle column b*
  logic [DEPTH_W-1:0] a0, a1, a2, b0, b1, b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a0 <= '0;
      a1 <= '0;
      a2 <= '0;
      b0 <= '0;
      b1 <= '0;
      b2 <= '0;
    end else if (s1_wr) begin
      a0 <= b0;
      a1 <= b1;
      a2 <= b2;
      b0 <= s1_t;
      b1 <= s1_m;
      b2 <= s1_x;
    end
  end

  // Sobel sums and clamp to the unsigned 16-bit range
  function automatic logic [DEPTH_W-1:0] clamp16(input logic signed [SUM_W:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({2'b00, {DEPTH_W{1'b1}}})) begin
      return '1;
    end else begin
      return v[DEPTH_W-1:0];
    end
  endfunction

  logic [SUM_W-1:0]     v_pos, v_neg, h_pos, h_neg;
  logic signed [SUM_W:0] v_raw, h_raw;

  always_comb begin
    v_pos = SUM_W'(s1_t) + {(SUM_W-1)'(s1_m), 1'b0} + SUM_W'(s1_x);
    v_neg = SUM_W'(a0) + {(SUM_W-1)'(a1), 1'b0} + SUM_W'(a2);
    h_pos = SUM_W'(a0) + {(SUM_W-1)'(b0), 1'b0} + SUM_W'(s1_t);
    h_neg = SUM_W'(a2) + {(SUM_W-1)'(b2), 1'b0} + SUM_W'(s1_x);
    v_raw = $signed({1'b0, v_pos}) - $signed({1'b0, v_neg});
    h_raw = $signed({1'b0, h_pos}) - $signed({1'b0, h_neg});
  end

  // Stage 2: clamped gradients
  logic               s2_valid, s2_last;
  logic [DEPTH_W-1:0] s2_v, s2_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_info.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_info.last;
      s2_v    <= s1_info.border ? '0 : clamp16(v_raw);
      s2_h    <= s1_info.border ? '0 : clamp16(h_raw);
    end
  end

  // Stage 3: squared gradients
  logic            s3_valid, s3_last;
  logic [SQ_W-1:0] s3_vv, s3_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      s3_vv   <= s2_v * s2_v;
      s3_hh   <= s2_h * s2_h;
    end
  end

  // Result register: magnitude compare against the threshold
  logic [SQ_W:0]     mag_sq;
  logic [EDGE_W-1:0] o_edge;
  logic              o_last;

  assign mag_sq = {1'b0, s3_vv} + {1'b0, s3_hh};

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_edge <= (mag_sq >= {1'b0, thr_sq}) ? EDGE_ON : EDGE_OFF;
      o_last <= s3_last;
    end
  end

  assign edge_out.valid         = o_valid;
  assign edge_out.edge_res      = o_edge;
  assign edge_out.last_of_frame = o_last;

  // Line store read never hits the column being written back
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (acc && s1_wr) |-> (col != s1_addr))
    else $error("line store read and write at the same column");

  // A finished result moving on reaches the output
  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && adv) |=> edge_out.valid)
    else $error("result lost between compare and output");

  // The edge map is binary
  a_binary_map: assert property (@(posedge clk) disable iff (rst)
    edge_out.valid |-> (edge_out.edge_res == EDGE_ON || edge_out.edge_res == EDGE_OFF))
    else $error("edge map value is neither on nor off");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Sobel edge threshold block
// Streams depth frames and flush requests through the pixel channel with
// random gaps and output stalls, and predicts each edge map pixel with an
// independent line buffer and window model. Every accepted result is compared
// in order against the prediction. The run walks through several register
// settings, among them clamped sizes, a tall frame, and size changes in
// mid-frame.
// ----------------------------------------------------------------------------
module tb_top;
  import sedge_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      CLK_PERIOD   = 10;
  localparam int      RESET_CYCLES = 4;
  localparam int      MAX_W        = 1024;
  localparam int      MAX_H        = 1024;
  localparam int      FILL_W       = 48;
  localparam int      SETTLE       = 8;
  localparam int      RAND_ITEMS   = 1150;
  localparam longint  TIMEOUT_NS   = 64'd10_000_000;

  typedef struct packed {
    logic               req_type;
    logic [DEPTH_W-1:0] depth;
  } depth_req_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_res;
    logic              last_of_frame;
  } edge_pix_t;

  typedef enum int {PAT_NOISE, PAT_TEXTURE, PAT_RAMP, PAT_BINARY, PAT_FLAT} pattern_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sedge_in_if  pix_if ();
  sedge_out_if edge_if ();

  sobel_edge_threshold_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_if),
    .edge_out  (edge_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Requests waiting for the driver, and edge pixels waiting for the block
  depth_req_t depth_reqs[$];
  edge_pix_t  expected_edges[$];

  // Shadow of the block: register copies, line buffer, window, positions
  logic [THR_W-1:0]   thr_reg;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [DEPTH_W-1:0] line_mem [2 * MAX_W];
  logic [DEPTH_W-1:0] win_col [6];
  int unsigned        px_row, px_col, res_row, res_col;

  int unsigned fail_cnt, n_pixels, n_flushes, n_results, n_edges, n_frames, n_writes;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw, input int unsigned cap);
    if (raw < 3) return 3;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic int clip16(input int x);
    if (x < 0) return 0;
    if (x > 65535) return 65535;
    return x;
  endfunction

  // Compare squared magnitude against squared threshold, no square root needed
  function automatic logic [EDGE_W-1:0] edge_decision(input int v, input int hs);
    longint unsigned vv, hh, tt;
    vv = clip16(v);
    hh = clip16(hs);
    tt = thr_reg;
    return (vv * vv + hh * hh >= tt * tt) ? EDGE_ON : EDGE_OFF;
  endfunction

  // Work out the edge pixel (if any) that one accepted request produces
  function automatic void compute_edges(input logic rtype, input logic [DEPTH_W-1:0] dval);
    int unsigned w, h, r, c, ci, orow, ocol;
    int          t, m, x, a0, a1, a2, b0, b2, v, hs;
    bit          border;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);

    // Flush: drain one tail pixel, only at a frame boundary with work pending
    if (rtype == REQ_FLUSH) begin
      if (px_row != 0 || px_col != 0) return;
      if (res_row == 0 && res_col == 0) return;
      if (res_row >= h - 1 && res_col >= w - 1) begin
        expected_edges.push_back('{edge_res: edge_decision(0, 0), last_of_frame: 1'b1});
        res_row = 0;
        res_col = 0;
      end else begin
        expected_edges.push_back('{edge_res: edge_decision(0, 0), last_of_frame: 1'b0});
        if (res_col >= w - 1) begin
          res_col = 0;
          res_row++;
          if (res_row > h - 1) begin
            res_row = 0;
            res_col = 0;
          end
        end else begin
          res_col++;
        end
      end
      return;
    end

    r  = px_row;
    c  = px_col;
    x  = dval;
    ci = (c < MAX_W) ? c : MAX_W - 1;
    if (r == 0 && c == 0) begin
      res_row = 0;
      res_col = 0;
    end

    // Shift the column through the two row buffers
    t = line_mem[MAX_W + ci];
    m = line_mem[ci];
    line_mem[MAX_W + ci] = DEPTH_W'(m);
    line_mem[ci]         = dval;

    a0 = win_col[0]; a1 = win_col[1]; a2 = win_col[2];
    b0 = win_col[3]; b2 = win_col[5];
    v  = (t + 2 * m + x) - (a0 + 2 * a1 + a2);
    hs = (a0 + 2 * b0 + t) - (a2 + 2 * b2 + x);

    // Advance the 3x3 window by one column
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = DEPTH_W'(t);
    win_col[4] = DEPTH_W'(m);
    win_col[5] = dval;

    // Emit the pixel one row and one column behind
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        orow = r - 1;
        ocol = c - 1;
      end else begin
        orow = r - 2;
        ocol = w - 1;
      end
      border = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol >= w - 1);
      expected_edges.push_back('{edge_res: border ? edge_decision(0, 0) : edge_decision(v, hs),
                                 last_of_frame: 1'b0});
      if (ocol >= w - 1) begin
        res_row = orow + 1;
        res_col = 0;
      end else begin
        res_row = orow;
        res_col = ocol + 1;
      end
    end

    // Advance the input position, wrapping on the sizes now in force
    if (c >= w - 1) begin
      px_col = 0;
      px_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      px_col = c + 1;
    end
  endfunction

  // Pixels still needed to close the current input frame
  function automatic int unsigned frame_rest();
    int unsigned w, h, rest;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    if (px_row == 0 && px_col == 0) return 0;
    rest = (px_col >= w - 1) ? 1 : w - px_col;
    if (px_row < h - 1) rest += (h - 1 - px_row) * w;
    return rest;
  endfunction

  // Mostly short gaps, a few long ones, none while in a burst
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg    = val[THR_W-1:0];
      CFG_WIDTH:     width_reg  = val[DIM_W-1:0];
      CFG_HEIGHT:    height_reg = val[DIM_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Hold until every request is taken and every result is back, then let
  // in-flight requests that make no result clear the pipeline; sample away
  // from the rising edge so the driver's and monitor's updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (depth_reqs.size() != 0 || pix_if.valid || expected_edges.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_req(input logic rtype, input logic [DEPTH_W-1:0] dval);
    depth_reqs.push_back('{req_type: rtype, depth: dval});
  endtask

  task automatic push_flushes(input int unsigned n);
    repeat (n) push_req(REQ_FLUSH, DEPTH_W'($urandom));
  endtask

  // Queue n pixels of one texture, optionally sprinkled with stray flushes
  task automatic push_pixels(input int unsigned n, input pattern_t pat, input bit noisy);
    logic [DEPTH_W-1:0] base, step, d;
    base = DEPTH_W'($urandom);
    step = DEPTH_W'($urandom_range(1, 4000));
    for (int unsigned k = 0; k < n; k++) begin
      case (pat)
        PAT_NOISE:   d = DEPTH_W'($urandom);
        PAT_TEXTURE: d = base + DEPTH_W'($urandom_range(0, 1023));
        PAT_RAMP:    d = base + DEPTH_W'(k * step);
        PAT_BINARY: begin
          if ($urandom_range(0, 1) == 1) d = {DEPTH_W{1'b1}};
          else d = '0;
        end
        default:     d = base;
      endcase
      push_req(REQ_PIXEL, d);
      if (noisy && k + 1 < n && $urandom_range(0, 99) == 0) push_flushes(1);
    end
  endtask

  // Pick new settings; small frames mostly, clamped sizes now and then
  task automatic random_config();
    logic [CFG_DATA_W-1:0] data;
    int unsigned           roll;
    if ($urandom_range(0, 99) < 60) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) data = '0;
      else if (roll < 20) data = {CFG_DATA_W{1'b1}};
      else if (roll < 50) data = CFG_DATA_W'($urandom_range(0, 2000));
      else data = CFG_DATA_W'($urandom);
      write_reg(CFG_THRESHOLD, data);
    end
    if ($urandom_range(0, 99) < 60) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) data = CFG_DATA_W'($urandom_range(3, 8));
      else if (roll < 85) data = CFG_DATA_W'($urandom_range(9, 24));
      else if (roll < 92) data = CFG_DATA_W'($urandom_range(25, FILL_W));
      else data = CFG_DATA_W'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) data[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom);
      write_reg(CFG_WIDTH, data);
    end
    if ($urandom_range(0, 99) < 60) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) data = CFG_DATA_W'($urandom_range(3, 6));
      else if (roll < 90) data = CFG_DATA_W'($urandom_range(7, 12));
      else data = CFG_DATA_W'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) data[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom);
      write_reg(CFG_HEIGHT, data);
    end
  endtask

  // Driver: present queued requests, hold while not taken, idle at random
  always @(posedge clk) begin : drive_requests
    int unsigned gap_cnt;
    bit          in_burst;
    depth_req_t  req;
    if (rst) begin
      pix_if.valid    <= 1'b0;
      pix_if.req_type <= REQ_PIXEL;
      pix_if.depth    <= '0;
      gap_cnt  = 0;
      in_burst = 1'b0;
    end else if (!(pix_if.valid && !pix_if.ready)) begin
      if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      if (gap_cnt > 0) begin
        pix_if.valid <= 1'b0;
        gap_cnt--;
      end else if (depth_reqs.size() > 0) begin
        req = depth_reqs.pop_front();
        pix_if.valid    <= 1'b1;
        pix_if.req_type <= req.req_type;
        pix_if.depth    <= req.depth;
        gap_cnt = pick_gap(in_burst);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each taken result, then predict from each taken request
  always @(posedge clk) begin : track_and_check
    int unsigned stall_cnt, n;
    bit          out_burst;
    edge_pix_t   want;
    if (rst) begin
      edge_if.ready <= 1'b0;
      stall_cnt = 0;
      out_burst = 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready) begin
        n_results++;
        if (edge_if.edge_res == EDGE_ON) n_edges++;
        if (edge_if.last_of_frame) n_frames++;
        if (expected_edges.size() == 0) begin
          $error("edge result with none expected: edge_res=%0d last_of_frame=%0b",
                 edge_if.edge_res, edge_if.last_of_frame);
          fail_cnt++;
        end else begin
          want = expected_edges.pop_front();
          if (edge_if.edge_res !== want.edge_res) begin
            $error("edge_res mismatch: expected %0d, actual %0d", want.edge_res, edge_if.edge_res);
            fail_cnt++;
          end
          if (edge_if.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame mismatch: expected %0b, actual %0b",
                   want.last_of_frame, edge_if.last_of_frame);
            fail_cnt++;
          end
        end
      end

      if (pix_if.valid && pix_if.ready) begin
        if (pix_if.req_type == REQ_FLUSH) n_flushes++;
        else n_pixels++;
        compute_edges(pix_if.req_type, pix_if.depth);
      end

      // Stall the result side at random
      if ($urandom_range(0, 127) == 0) out_burst = !out_burst;
      if (stall_cnt > 0) begin
        edge_if.ready <= 1'b0;
        stall_cnt--;
      end else begin
        n = pick_gap(out_burst);
        edge_if.ready <= (n == 0);
        stall_cnt = (n > 0) ? n - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, n, nf, gen_left, rand_items, roll;
    bit          force_cfg;
    pattern_t    pat;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_THRESHOLD;
    cfg_data        = '0;

    thr_reg    = THRESHOLD_RST;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win_col[i]) win_col[i] = '0;
    px_row  = 0;
    px_col  = 0;
    res_row = 0;
    res_col = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Top threshold, sizes below range (height write carries junk upper bits)
    write_reg(CFG_THRESHOLD, {CFG_DATA_W{1'b1}});
    write_reg(CFG_WIDTH, 16'h0000);
    write_reg(CFG_HEIGHT, 16'hF801);

    // Flush right after reset: nothing to drain
    push_flushes(1);
    // Bright right column: saturated vertical gradient; stray flush in mid-frame
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_req(REQ_PIXEL, (c == 2) ? {DEPTH_W{1'b1}} : '0);
        if (r == 1 && c == 0) push_flushes(1);
      end
    end
    // Drain only part of the tail, then start over: the rest is dropped
    push_flushes(2);
    // Bright top row: saturated horizontal gradient, full drain plus one spare
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) push_req(REQ_PIXEL, (r == 0) ? {DEPTH_W{1'b1}} : '0);
    end
    push_flushes(5);

    // Widest random row over a short frame; writes every line buffer column
    // that later frames reach, size changes in mid-frame included
    wait_idle();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(20000, 60000)));
    write_reg(CFG_WIDTH, CFG_DATA_W'(FILL_W));
    write_reg(CFG_HEIGHT, 16'd3);
    push_pixels(FILL_W * 3, PAT_NOISE, 1'b0);
    push_flushes(FILL_W + 1);

    // Zero threshold, tallest height, then shrink both sizes in mid-frame
    wait_idle();
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WIDTH, 16'd5);
    write_reg(CFG_HEIGHT, 16'd2047);
    push_pixels(33, PAT_NOISE, 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 16'd3);
    write_reg(CFG_HEIGHT, 16'd3);
    push_pixels(frame_rest(), PAT_NOISE, 1'b0);
    push_flushes(4);

    // Random frames: mostly whole frames and drains, some broken off
    rand_items = 0;
    gen_left   = 0;
    force_cfg  = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      if (force_cfg || $urandom_range(0, 99) < 35) begin
        wait_idle();
        random_config();
        gen_left  = frame_rest();
        force_cfg = 1'b0;
      end
      w = eff_dim(width_reg, MAX_W);
      h = eff_dim(height_reg, MAX_H);
      if (gen_left == 0) gen_left = w * h;
      pat = pattern_t'($urandom_range(0, 4));

      if ($urandom_range(0, 99) < 8) begin
        // Break the frame off and change settings in mid-frame
        n = $urandom_range(0, gen_left - 1);
        push_pixels(n, pat, 1'b1);
        push_flushes(1);
        gen_left   -= n;
        rand_items += n;
        force_cfg   = 1'b1;
      end else begin
        push_pixels(gen_left, pat, 1'b1);
        rand_items += gen_left;
        gen_left    = 0;
        roll = $urandom_range(0, 99);
        if (roll < 12) nf = $urandom_range(0, w);
        else if (roll < 30) nf = w + 1 + $urandom_range(1, 3);
        else nf = w + 1;
        push_flushes(nf);
        rand_items += (nf < w + 1) ? nf : w + 1;
      end
    end

    wait_idle();
    $display("Run covered %0d depth pixels and %0d flush requests over %0d register writes",
             n_pixels, n_flushes, n_writes);
    $display("Checked %0d edge map pixels: %0d edges, %0d frames closed",
             n_results, n_edges, n_frames);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: end the run with a failure if it has not finished by TIMEOUT_NS
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sedge_pkg.sv
design/sedge_in_if.sv
design/sedge_out_if.sv
design/sedge_ctrl.sv
design/sobel_edge_threshold_top.sv
tb/tb_top.sv
